### hdl/heap_region_access_checker_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heap region access checker.
// Every property is clocked on clk and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HEAP_REGION_ACCESS_CHECKER_TOP_ASSERT_SVH
`define HEAP_REGION_ACCESS_CHECKER_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define HRAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition in one cycle that forces another in the cycle after.
`define HRAC_ASSERT_NEXT(lbl, pre, post, msg) \
    `HRAC_ASSERT(lbl, (pre) |=> (post), msg)

`endif

### hdl/hrac_pkg.sv
// ----------------------------------------------------------------------------
// hrac_pkg
// Widths, codes, sequencer states and the table entry type of the heap
// region access checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hrac_pkg;

    localparam int HRAC_TABLE_DEPTH = 1024;

    localparam int OP_W     = 2;
    localparam int MODE_W   = 2;
    localparam int WORD_W   = 64;
    localparam int SCALE_W  = 4;
    localparam int DISP_W   = 32;
    localparam int STATUS_W = 3;
    localparam int RIDX_W   = 10;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_ACCESS = 2'd2;

    // Address forming modes.
    localparam logic [MODE_W-1:0] MODE_BASE_INDEX = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ABSOLUTE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PC_REL     = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_STORED      = 3'd0;
    localparam logic [STATUS_W-1:0] STS_TABLE_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FREED       = 3'd2;
    localparam logic [STATUS_W-1:0] STS_DOUBLE_FREE = 3'd3;
    localparam logic [STATUS_W-1:0] STS_OUTSIDE     = 3'd4;
    localparam logic [STATUS_W-1:0] STS_PASS        = 3'd5;
    localparam logic [STATUS_W-1:0] STS_FAIL        = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD_BASE,
        S_ADD_DISP,
        S_ADD_PC,
        S_CHECK,
        S_SCAN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] base;
        logic [WORD_W-1:0] size;
        logic              active;
    } entry_t;

endpackage

`default_nettype wire

### hdl/hrac_if.sv
// ----------------------------------------------------------------------------
// hrac_req_if / hrac_rsp_if
// Valid/ready channels that carry request and response beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrac_req_if import hrac_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic [MODE_W-1:0]        addr_mode;
    logic [WORD_W-1:0]        base_value;
    logic [WORD_W-1:0]        index_value;
    logic [SCALE_W-1:0]       scale;
    logic signed [DISP_W-1:0] displacement;
    logic [WORD_W-1:0]        direct_address;
    logic [WORD_W-1:0]        pc;
    logic [WORD_W-1:0]        pointer;
    logic [WORD_W-1:0]        alloc_size;

    modport source (
        output valid, opcode, addr_mode, base_value, index_value, scale,
               displacement, direct_address, pc, pointer, alloc_size,
        input  ready
    );
    modport sink (
        input  valid, opcode, addr_mode, base_value, index_value, scale,
               displacement, direct_address, pc, pointer, alloc_size,
        output ready
    );
endinterface

interface hrac_rsp_if import hrac_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [RIDX_W-1:0]   region_index;
    logic [WORD_W-1:0]   pass_total;
    logic [WORD_W-1:0]   fail_total;
    logic                all_passed;

    modport source (
        output valid, status, region_index, pass_total, fail_total, all_passed,
        input  ready
    );
    modport sink (
        input  valid, status, region_index, pass_total, fail_total, all_passed,
        output ready
    );
endinterface

`default_nettype wire

### hdl/hrac_table.sv
// ----------------------------------------------------------------------------
// hrac_table
// Region table storage: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hrac_table import hrac_pkg::*; #(
    parameter int DEPTH = HRAC_TABLE_DEPTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  entry_t                   wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                   rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hdl/heap_region_access_checker_top.sv
// ----------------------------------------------------------------------------
// heap_region_access_checker_top
// Tracks allocated heap regions and checks memory accesses against them.
//
//   channel | dir | beat contents
//   --------+-----+-----------------------------------------------------------
//   req     | in  | opcode, address operands, pointer and size
//   rsp     | out | status, region index, pass and fail totals, all-passed
//
// An allocation writes its entry and goes straight to its response beat. A
// release walks the stored table entries; an access first forms its address,
// by a shared adder in the base-index and pc-relative modes, then walks them,
// at most TABLE_DEPTH entries, one entry a cycle through the single read port.
// No request beat is taken while an item is in work or its response waits.
// Reset clears the entry count and counters and sets all_passed; the table
// needs no clearing pass since entries at or above the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_region_access_checker_top import hrac_pkg::*; #(
    parameter int TABLE_DEPTH = HRAC_TABLE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    hrac_req_if.sink   req,
    hrac_rsp_if.source rsp
);

    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IW + 1;

    // Control state.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IW-1:0]    scan_idx_reg, scan_idx_next;
    logic [WORD_W-1:0] pass_reg, pass_next;
    logic [WORD_W-1:0] fail_reg, fail_next;
    logic             clean_reg, clean_next;

    // Item operands and result payload.
    logic [WORD_W-1:0]        opd_base_reg, opd_base_next;
    logic [WORD_W-1:0]        opd_index_reg, opd_index_next;
    logic [SCALE_W-1:0]       scale_reg, scale_next;
    logic signed [DISP_W-1:0] disp_reg, disp_next;
    logic [WORD_W-1:0]        direct_reg, direct_next;
    logic [WORD_W-1:0]        pc_reg, pc_next;
    logic [WORD_W-1:0]        prod_reg, prod_next;
    logic [WORD_W-1:0]        addr_reg, addr_next;
    logic                     is_free_reg, is_free_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [RIDX_W-1:0]        ridx_reg, ridx_next;

    // Table port.
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;
    entry_t        rd_data;

    // Shared adder and scan compare.
    logic [WORD_W-1:0] alu_a, alu_b, alu_sum;
    logic [WORD_W:0]   diff;
    logic              in_region;
    logic              hit;
    logic [CNT_W-1:0]  idx_plus;
    logic              last;
    logic              full;

    hrac_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (scan_idx_next),
        .rd_data (rd_data)
    );

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = (state_reg == S_RESP);
    assign rsp.status       = status_reg;
    assign rsp.region_index = ridx_reg;
    assign rsp.pass_total   = pass_reg;
    assign rsp.fail_total   = fail_reg;
    assign rsp.all_passed   = clean_reg;

    assign alu_sum   = alu_a + alu_b;
    assign diff      = {1'b0, addr_reg} - {1'b0, rd_data.base};
    assign in_region = !diff[WORD_W] && (diff[WORD_W-1:0] < rd_data.size);
    assign hit       = rd_data.active &&
                       (is_free_reg ? (rd_data.base == addr_reg) : in_region);
    assign idx_plus  = {1'b0, scan_idx_reg} + {{IW{1'b0}}, 1'b1};
    assign last      = (idx_plus == count_reg);
    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = '0;
        pass_next      = pass_reg;
        fail_next      = fail_reg;
        clean_next     = clean_reg;
        opd_base_next  = opd_base_reg;
        opd_index_next = opd_index_reg;
        scale_next     = scale_reg;
        disp_next      = disp_reg;
        direct_next    = direct_reg;
        pc_next        = pc_reg;
        prod_next      = prod_reg;
        addr_next      = addr_reg;
        is_free_next   = is_free_reg;
        status_next    = status_reg;
        ridx_next      = ridx_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[IW-1:0];
        wr_data        = '{base: req.pointer, size: req.alloc_size, active: 1'b1};
        alu_a          = addr_reg;
        alu_b          = {{(WORD_W-DISP_W){disp_reg[DISP_W-1]}}, disp_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    opd_base_next  = (req.addr_mode == MODE_BASE_INDEX) ?
                                     req.base_value : '0;
                    opd_index_next = req.index_value;
                    scale_next     = req.scale;
                    disp_next      = req.displacement;
                    direct_next    = req.direct_address;
                    pc_next        = req.pc;
                    ridx_next      = '0;
                    case (req.opcode)
                        OP_ALLOC:
                        begin
                            if (full)
                            begin
                                status_next = STS_TABLE_FULL;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                count_next  = count_reg + {{IW{1'b0}}, 1'b1};
                                status_next = STS_STORED;
                                ridx_next   = RIDX_W'(count_reg[IW-1:0]);
                            end
                            state_next = S_RESP;
                        end
                        OP_FREE:
                        begin
                            is_free_next = 1'b1;
                            addr_next    = req.pointer;
                            if (count_reg == '0)
                            begin
                                status_next = STS_DOUBLE_FREE;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_ACCESS:
                        begin
                            is_free_next = 1'b0;
                            case (req.addr_mode)
                                MODE_BASE_INDEX:
                                begin
                                    state_next = S_MUL;
                                end
                                MODE_ABSOLUTE:
                                begin
                                    addr_next  = req.direct_address;
                                    state_next = S_CHECK;
                                end
                                MODE_PC_REL:
                                begin
                                    addr_next = '0;
                                    if (req.direct_address != '0 && req.pc != '0)
                                    begin
                                        state_next = S_ADD_PC;
                                    end
                                    else
                                    begin
                                        state_next = S_CHECK;
                                    end
                                end
                                default:
                                begin
                                    addr_next  = '0;
                                    state_next = S_CHECK;
                                end
                            endcase
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next  = opd_index_reg * {{(WORD_W-SCALE_W){1'b0}}, scale_reg};
                state_next = S_ADD_BASE;
            end
            S_ADD_BASE:
            begin
                alu_a      = opd_base_reg;
                alu_b      = prod_reg;
                addr_next  = alu_sum;
                state_next = S_ADD_DISP;
            end
            S_ADD_DISP:
            begin
                addr_next  = alu_sum;
                state_next = S_CHECK;
            end
            S_ADD_PC:
            begin
                alu_a      = pc_reg;
                alu_b      = direct_reg;
                addr_next  = alu_sum;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // A null address never lies in a region.
                if (addr_reg == '0 || count_reg == '0)
                begin
                    status_next = STS_OUTSIDE;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // rd_data holds the entry at scan_idx_reg.
                if (hit)
                begin
                    ridx_next = RIDX_W'(scan_idx_reg);
                    if (is_free_reg)
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = scan_idx_reg;
                        wr_data     = '{base: rd_data.base, size: rd_data.size,
                                        active: 1'b0};
                        status_next = STS_FREED;
                    end
                    else if (opd_base_reg == rd_data.base)
                    begin
                        pass_next   = pass_reg + {{(WORD_W-1){1'b0}}, 1'b1};
                        status_next = STS_PASS;
                    end
                    else
                    begin
                        fail_next   = fail_reg + {{(WORD_W-1){1'b0}}, 1'b1};
                        clean_next  = 1'b0;
                        status_next = STS_FAIL;
                    end
                    state_next = S_RESP;
                end
                else if (last)
                begin
                    ridx_next   = '0;
                    status_next = is_free_reg ? STS_DOUBLE_FREE : STS_OUTSIDE;
                    state_next  = S_RESP;
                end
                else
                begin
                    scan_idx_next = idx_plus[IW-1:0];
                end
            end
            S_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            pass_reg     <= '0;
            fail_reg     <= '0;
            clean_reg    <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            pass_reg     <= pass_next;
            fail_reg     <= fail_next;
            clean_reg    <= clean_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opd_base_reg  <= opd_base_next;
        opd_index_reg <= opd_index_next;
        scale_reg     <= scale_next;
        disp_reg      <= disp_next;
        direct_reg    <= direct_next;
        pc_reg        <= pc_next;
        prod_reg      <= prod_next;
        addr_reg      <= addr_next;
        is_free_reg   <= is_free_next;
        status_reg    <= status_next;
        ridx_reg      <= ridx_next;
    end

endmodule

`default_nettype wire

### hdl/hrac_checker.sv
// ----------------------------------------------------------------------------
// hrac_checker
// Port-level assertions for the heap region access checker, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "heap_region_access_checker_top_assert.svh"

module hrac_checker import hrac_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] status,
    input logic [RIDX_W-1:0]   region_index,
    input logic                all_passed
);

    // The block takes a new beat only once the last response is gone.
    `HRAC_ASSERT(a_req_blocked_by_rsp, req_ready |-> !rsp_valid, "request taken with response pending")

    `HRAC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(region_index), "stalled response changed")

    // Once a failing access is seen the flag stays low until reset.
    `HRAC_ASSERT_NEXT(a_clean_sticky, !all_passed, !all_passed, "all_passed rose again")

    `HRAC_ASSERT(a_fail_clears_flag, rsp_valid && status == STS_FAIL |-> !all_passed, "fail reported with all_passed high")

    `HRAC_ASSERT(a_miss_index_zero, rsp_valid && (status == STS_TABLE_FULL || status == STS_DOUBLE_FREE || status == STS_OUTSIDE) |-> region_index == '0, "miss carries a nonzero index")

endmodule

bind heap_region_access_checker_top hrac_checker u_hrac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .region_index (rsp.region_index),
    .all_passed   (rsp.all_passed)
);

`default_nettype wire
